>>> rtl/assert_macros.svh
// Assertion helpers included by the hasher top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define XH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define XH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

>>> rtl/xxh64_pkg.sv
// ----------------------------------------------------------------------------
// xxh64_pkg
// Primes, sequencer state codes and rotate helper for the xxHash64 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package xxh64_pkg;

  localparam logic [63:0] Prime1 = 64'd11400714785074694791;
  localparam logic [63:0] Prime2 = 64'd14029467366897019727;
  localparam logic [63:0] Prime3 = 64'd1609587929392839161;
  localparam logic [63:0] Prime4 = 64'd9650029242287828579;
  localparam logic [63:0] Prime5 = 64'd2870177450012600261;

  typedef enum logic [27:0] {
    S_IDLE  = 28'h0000001,
    S_LANEA = 28'h0000002,
    S_LANEB = 28'h0000004,
    S_LANEC = 28'h0000008,
    S_FIN   = 28'h0000010,
    S_CONV  = 28'h0000020,
    S_MRGA  = 28'h0000040,
    S_MRGB  = 28'h0000080,
    S_MRGC  = 28'h0000100,
    S_MRGD  = 28'h0000200,
    S_TOT   = 28'h0000400,
    S_TSEL  = 28'h0000800,
    S_T8A   = 28'h0001000,
    S_T8B   = 28'h0002000,
    S_T8C   = 28'h0004000,
    S_T8D   = 28'h0008000,
    S_T4A   = 28'h0010000,
    S_T4B   = 28'h0020000,
    S_T4C   = 28'h0040000,
    S_T1A   = 28'h0080000,
    S_T1B   = 28'h0100000,
    S_T1C   = 28'h0200000,
    S_AVA   = 28'h0400000,
    S_AVB   = 28'h0800000,
    S_AVC   = 28'h1000000,
    S_MUL0  = 28'h2000000,
    S_MUL1  = 28'h4000000,
    S_MUL2  = 28'h8000000
  } state_e;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

`default_nettype wire

>>> rtl/xxh64_if.sv
// ----------------------------------------------------------------------------
// xxh64_if
// Valid/ready channels: message words in, hash values out.
// ----------------------------------------------------------------------------
`default_nettype none

interface xxh64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;
  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface xxh64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

>>> rtl/xxhash64_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher_top
// XXH64 of a message streamed as little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   hash_in_i  : one word per handshake; byte_count 0..8 valid bytes, first
//                byte in bits 7:0; a word shorter than 8 bytes ends the message.
//   hash_out_o : one hash per message, held in an output register.
//   cfg_we_i / cfg_data_i : write the seed while the block is idle.
// Input: a full word that neither completes a stripe nor ends the message
//   leaves the block idle and ready for the next word. A completed stripe
//   holds off input for four lane rounds, each two 64-bit products on the one
//   shared 32x32 multiplier.
// After the last word: the lane rounds if it completes a stripe, then lane sum
//   and merge (if a stripe was seen), a round per buffered word, a 4-byte tail
//   round and a round per tail byte, all bound by the shared multiplier.
// Reset: seed 0, no message in progress, output empty.
// Stall: a finished hash waits in the output register; the next message may
//   stream in meanwhile and its own hash waits until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module xxhash64_stream_hasher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_data_i,
  xxh64_in_if.sink         hash_in_i,
  xxh64_out_if.source      hash_out_o
);
  import xxh64_pkg::*;

  // control state
  state_e      state_q, state_d, ret_q, ret_d;
  logic [63:0] seed_q;
  logic [1:0]  fill_q, fill_d;     // full words buffered toward a stripe
  logic [1:0]  ix_q, ix_d;         // lane / buffered word index
  logic [2:0]  pc_q, pc_d;         // bytes left in the partial word
  logic [63:0] total_q, total_d;
  logic        seen_q, seen_d;
  logic        last_q, last_d;
  logic        ov_q, ov_d;

  // datapath
  logic [63:0] lane_q [4];
  logic [63:0] lane_d [4];
  logic [63:0] buf_q [4];
  logic [63:0] h_q, h_d, p_q, p_d, pp_q, pp_d, ma_q, ma_d, mb_q, mb_d;
  logic [31:0] cr_q, cr_d;
  logic [63:0] pw_q, pw_d, hash_q, hash_d;
  logic        buf_we;

  logic [31:0] mx, my;
  logic [63:0] mp;
  logic        acc;
  logic [3:0]  cnt;
  logic [63:0] word;
  logic [63:0] t;

  assign acc             = hash_in_i.valid && hash_in_i.ready;
  assign hash_in_i.ready = (state_q == S_IDLE);
  assign hash_out_o.valid      = ov_q;
  assign hash_out_o.hash_value = hash_q;

  // clamp count, drop bytes beyond it
  always_comb begin
    cnt  = (hash_in_i.byte_count > 4'd8) ? 4'd8 : hash_in_i.byte_count;
    word = hash_in_i.data_word;
    if (cnt < 4'd8) begin
      word = hash_in_i.data_word & ((64'd1 << {cnt[2:0], 3'b000}) - 64'd1);
    end
  end

  // shared 32x32 multiplier: three passes give the low 64 bits of a 64x64 product
  always_comb begin
    case (state_q)
      S_MUL1:  begin mx = ma_q[63:32]; my = mb_q[31:0];  end
      S_MUL2:  begin mx = ma_q[31:0];  my = mb_q[63:32]; end
      default: begin mx = ma_q[31:0];  my = mb_q[31:0];  end
    endcase
    mp = {32'd0, mx} * {32'd0, my};
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    fill_d  = fill_q;
    ix_d    = ix_q;
    pc_d    = pc_q;
    total_d = total_q;
    seen_d  = seen_q;
    last_d  = last_q;
    ov_d    = ov_q && !hash_out_o.ready;
    lane_d  = lane_q;
    h_d     = h_q;
    p_d     = p_q;
    pp_d    = pp_q;
    cr_d    = cr_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    pw_d    = pw_q;
    hash_d  = hash_q;
    buf_we  = 1'b0;
    t       = 64'd0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          total_d = total_q + {60'd0, cnt};
          last_d  = hash_in_i.last_word || (cnt < 4'd8);
          if (cnt == 4'd8) begin
            buf_we = 1'b1;
            pc_d   = 3'd0;
            if (fill_q == 2'd3) begin
              // stripe complete: load lanes from seed on the first one
              if (!seen_q) begin
                lane_d[0] = seed_q + Prime1 + Prime2;
                lane_d[1] = seed_q + Prime2;
                lane_d[2] = seed_q;
                lane_d[3] = seed_q - Prime1;
              end
              ix_d    = 2'd0;
              state_d = S_LANEA;
            end else begin
              fill_d = fill_q + 2'd1;
              if (hash_in_i.last_word) state_d = S_FIN;
            end
          end else begin
            pw_d    = word;
            pc_d    = cnt[2:0];
            state_d = S_FIN;
          end
        end
      end
      S_LANEA: begin
        ma_d = buf_q[ix_q]; mb_d = Prime2; ret_d = S_LANEB; state_d = S_MUL0;
      end
      S_LANEB: begin
        ma_d = rotl(lane_q[ix_q] + p_q, 31); mb_d = Prime1;
        ret_d = S_LANEC; state_d = S_MUL0;
      end
      S_LANEC: begin
        lane_d[ix_q] = p_q;
        ix_d = ix_q + 2'd1;
        if (ix_q == 2'd3) begin
          seen_d  = 1'b1;
          fill_d  = 2'd0;
          state_d = last_q ? S_FIN : S_IDLE;
        end else begin
          state_d = S_LANEA;
        end
      end
      S_FIN: begin
        ix_d = 2'd0;
        if (seen_q) begin
          h_d = 64'd0; state_d = S_CONV;
        end else begin
          h_d = seed_q + Prime5; state_d = S_TOT;
        end
      end
      S_CONV: begin
        case (ix_q)
          2'd0:    t = rotl(lane_q[0], 1);
          2'd1:    t = rotl(lane_q[1], 7);
          2'd2:    t = rotl(lane_q[2], 12);
          default: t = rotl(lane_q[3], 18);
        endcase
        h_d  = h_q + t;
        ix_d = ix_q + 2'd1;
        if (ix_q == 2'd3) state_d = S_MRGA;
      end
      S_MRGA: begin
        ma_d = lane_q[ix_q]; mb_d = Prime2; ret_d = S_MRGB; state_d = S_MUL0;
      end
      S_MRGB: begin
        ma_d = rotl(p_q, 31); mb_d = Prime1; ret_d = S_MRGC; state_d = S_MUL0;
      end
      S_MRGC: begin
        ma_d = h_q ^ p_q; mb_d = Prime1; ret_d = S_MRGD; state_d = S_MUL0;
      end
      S_MRGD: begin
        h_d  = p_q + Prime4;
        ix_d = ix_q + 2'd1;
        state_d = (ix_q == 2'd3) ? S_TOT : S_MRGA;
      end
      S_TOT: begin
        h_d = h_q + total_q; ix_d = 2'd0; state_d = S_TSEL;
      end
      S_TSEL: begin
        if (ix_q < fill_q)      state_d = S_T8A;
        else if (pc_q >= 3'd4)  state_d = S_T4A;
        else if (pc_q != 3'd0)  state_d = S_T1A;
        else                    state_d = S_AVA;
      end
      S_T8A: begin
        ma_d = buf_q[ix_q]; mb_d = Prime2; ret_d = S_T8B; state_d = S_MUL0;
      end
      S_T8B: begin
        ma_d = rotl(p_q, 31); mb_d = Prime1; ret_d = S_T8C; state_d = S_MUL0;
      end
      S_T8C: begin
        ma_d = rotl(h_q ^ p_q, 27); mb_d = Prime1; ret_d = S_T8D; state_d = S_MUL0;
      end
      S_T8D: begin
        h_d = p_q + Prime4; ix_d = ix_q + 2'd1; state_d = S_TSEL;
      end
      S_T4A: begin
        ma_d = {32'd0, pw_q[31:0]}; mb_d = Prime1; ret_d = S_T4B; state_d = S_MUL0;
      end
      S_T4B: begin
        ma_d = rotl(h_q ^ p_q, 23); mb_d = Prime2; ret_d = S_T4C; state_d = S_MUL0;
      end
      S_T4C: begin
        h_d = p_q + Prime3; pw_d = pw_q >> 32; pc_d = pc_q - 3'd4; state_d = S_TSEL;
      end
      S_T1A: begin
        ma_d = {56'd0, pw_q[7:0]}; mb_d = Prime5; ret_d = S_T1B; state_d = S_MUL0;
      end
      S_T1B: begin
        ma_d = rotl(h_q ^ p_q, 11); mb_d = Prime1; ret_d = S_T1C; state_d = S_MUL0;
      end
      S_T1C: begin
        h_d = p_q; pw_d = pw_q >> 8; pc_d = pc_q - 3'd1; state_d = S_TSEL;
      end
      S_AVA: begin
        ma_d = h_q ^ (h_q >> 33); mb_d = Prime2; ret_d = S_AVB; state_d = S_MUL0;
      end
      S_AVB: begin
        ma_d = p_q ^ (p_q >> 29); mb_d = Prime3; ret_d = S_AVC; state_d = S_MUL0;
      end
      S_AVC: begin
        // hold until the output slot is free
        if (!ov_q || hash_out_o.ready) begin
          hash_d  = p_q ^ (p_q >> 32);
          ov_d    = 1'b1;
          fill_d  = 2'd0;
          total_d = 64'd0;
          seen_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_MUL0: begin
        pp_d = mp; state_d = S_MUL1;
      end
      S_MUL1: begin
        cr_d = mp[31:0]; state_d = S_MUL2;
      end
      S_MUL2: begin
        p_d     = pp_q + {cr_q + mp[31:0], 32'd0};
        state_d = ret_q;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      seed_q  <= 64'd0;
      fill_q  <= 2'd0;
      ix_q    <= 2'd0;
      pc_q    <= 3'd0;
      total_q <= 64'd0;
      seen_q  <= 1'b0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (cfg_we_i) seed_q <= cfg_data_i;
      fill_q  <= fill_d;
      ix_q    <= ix_d;
      pc_q    <= pc_d;
      total_q <= total_d;
      seen_q  <= seen_d;
      last_q  <= last_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    if (buf_we) buf_q[fill_q] <= word;
    h_q    <= h_d;
    p_q    <= p_d;
    pp_q   <= pp_d;
    cr_q   <= cr_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    pw_q   <= pw_d;
    hash_q <= hash_d;
  end

  // a stalled hash stays put
  `XH_ASSERT(a_out_hold, clk_i, rst_ni, (ov_q && !hash_out_o.ready) |=> (ov_q && $stable(hash_q)))
  // a short word always ends the message
  `XH_ASSERT(a_short_ends, clk_i, rst_ni, (acc && (cnt < 4'd8)) |=> (state_q == S_FIN))
  // lanes are merged only after a stripe
  `XH_ASSERT(a_conv_seen, clk_i, rst_ni, (state_q == S_CONV) |-> seen_q)

endmodule

`default_nettype wire

>>> tb/xxh64_scoreboard.sv
// ----------------------------------------------------------------------------
// xxh64_scoreboard
// Bit-accurate XXH64 predictor with a queue of expected hashes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package xxh64_tb_pkg;
  import xxh64_pkg::*;

  class xxh64_scoreboard;
    logic [63:0] seed_q;
    logic [63:0] lanes [4];
    logic [63:0] stripe [4];
    int unsigned fill;
    logic [63:0] total;
    bit          stripe_seen;
    logic [63:0] hash_q [$];
    int unsigned mismatches;
    int unsigned hashes_checked;

    function new();
      seed_q = '0;
      fill = 0;
      total = '0;
      stripe_seen = 0;
      mismatches = 0;
      hashes_checked = 0;
    endfunction

    function automatic logic [63:0] rot(logic [63:0] x, int unsigned r);
      if (r == 0) return x;
      return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] round_mix(logic [63:0] acc, logic [63:0] lane);
      acc = acc + lane * Prime2;
      acc = rot(acc, 31);
      return acc * Prime1;
    endfunction

    function void set_seed(logic [63:0] v);
      seed_q = v;
    endfunction

    // Absorb one accepted word; queue a hash when it ends the message.
    function void note_word(logic [63:0] word, logic [3:0] cnt_in, logic last_in);
      int unsigned cnt;
      bit          last;
      logic [7:0]  tail [32];
      int unsigned n;
      int unsigned pos;
      logic [63:0] h;
      logic [63:0] v;
      cnt = (cnt_in > 8) ? 8 : cnt_in;
      last = last_in;
      n = 0;
      if (cnt < 8) begin
        last = 1;
        for (int b = 0; b < 8; b++) if (b >= cnt) word[8*b +: 8] = 8'h00;
      end
      total = total + cnt;
      if (cnt == 8) begin
        stripe[(fill >> 3) & 3] = word;
        fill += 8;
        if (fill >= 32) begin
          if (!stripe_seen) begin
            lanes[0] = seed_q + Prime1 + Prime2;
            lanes[1] = seed_q + Prime2;
            lanes[2] = seed_q;
            lanes[3] = seed_q - Prime1;
          end
          for (int i = 0; i < 4; i++) lanes[i] = round_mix(lanes[i], stripe[i]);
          stripe_seen = 1;
          fill = 0;
        end
      end
      if (!last) return;
      for (int i = 0; i < (fill >> 3); i++)
        for (int b = 0; b < 8; b++) tail[n++] = stripe[i][8*b +: 8];
      if (cnt < 8)
        for (int b = 0; b < cnt; b++) tail[n++] = word[8*b +: 8];
      if (stripe_seen) begin
        h = rot(lanes[0], 1) + rot(lanes[1], 7) + rot(lanes[2], 12) + rot(lanes[3], 18);
        for (int i = 0; i < 4; i++) begin
          h = h ^ round_mix(64'd0, lanes[i]);
          h = h * Prime1 + Prime4;
        end
      end else begin
        h = seed_q + Prime5;
      end
      h = h + total;
      pos = 0;
      while (pos + 8 <= n) begin
        v = '0;
        for (int b = 0; b < 8; b++) v[8*b +: 8] = tail[pos + b];
        h = h ^ round_mix(64'd0, v);
        h = rot(h, 27) * Prime1 + Prime4;
        pos += 8;
      end
      if (pos + 4 <= n) begin
        v = '0;
        for (int b = 0; b < 4; b++) v[8*b +: 8] = tail[pos + b];
        h = h ^ (v * Prime1);
        h = rot(h, 23) * Prime2 + Prime3;
        pos += 4;
      end
      while (pos < n) begin
        h = h ^ ({56'd0, tail[pos]} * Prime5);
        h = rot(h, 11) * Prime1;
        pos++;
      end
      h = h ^ (h >> 33);
      h = h * Prime2;
      h = h ^ (h >> 29);
      h = h * Prime3;
      h = h ^ (h >> 32);
      hash_q.push_back(h);
      fill = 0;
      total = '0;
      stripe_seen = 0;
    endfunction

    function void check_hash(logic [63:0] got);
      logic [63:0] want;
      if (hash_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected hash %h", got);
        return;
      end
      want = hash_q.pop_front();
      hashes_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("hash mismatch: expected %h, actual %h", want, got);
      end
    endfunction
  endclass
endpackage

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams messages of random length and content through the hasher, with
// bursty input and a stalling receiver, and checks each hash against an
// in-bench XXH64 predictor across several seeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import xxh64_tb_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 600;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_data_i;

  xxh64_in_if  hash_in ();
  xxh64_out_if hash_out ();

  xxhash64_stream_hasher_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .hash_in_i  (hash_in.sink),
    .hash_out_o (hash_out.source)
  );

  xxh64_scoreboard hash_sb;
  int unsigned     words_sent;
  int unsigned     idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    hash_sb = new();
  end

  // Receiver: stall on a pattern that changes now and then; check each hash.
  initial begin
    int unsigned mode;
    hash_out.ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hash_out.valid && hash_out.ready) hash_sb.check_hash(hash_out.hash_value);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: hash_out.ready <= 1'b1;
        1: hash_out.ready <= ($urandom_range(0, 3) != 0);
        2: hash_out.ready <= ($urandom_range(0, 3) == 0);
        default: hash_out.ready <= ($urandom_range(0, 40) == 0);
      endcase
    end
  end

  // Watchdog: count cycles in which no word and no hash is accepted.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((hash_in.valid && hash_in.ready) || (hash_out.valid && hash_out.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Burst state of the sender: gaps between bursts of random length.
  int unsigned burst_left;

  // Offer one word, hold it until accepted, note it with the predictor.
  // Valid stays high after acceptance so the next word follows back to back;
  // drop it before any gap or pause.
  task automatic send_word(logic [63:0] w, logic [3:0] c, logic l);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
      burst_left = $urandom_range(1, 20);
    end
    if (gap != 0) begin
      hash_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    hash_in.valid      <= 1'b1;
    hash_in.data_word  <= w;
    hash_in.byte_count <= c;
    hash_in.last_word  <= l;
    do @(posedge clk_i); while (!hash_in.ready);
    hash_sb.note_word(w, c, l);
    words_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Message of full words, then a closing word with a byte count of 0..15.
  task automatic send_message(int unsigned full_words, logic [3:0] tail_cnt);
    for (int i = 0; i < full_words; i++) send_word(rand64(), 4'd8, 1'b0);
    send_word(rand64(), tail_cnt, 1'b1);
  endtask

  // Wait until every expected hash is in, then let the block settle.
  task automatic drain();
    hash_in.valid <= 1'b0;
    while (hash_sb.hash_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [63:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    hash_sb.set_seed(v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] seeds [4];
    int unsigned r;
    int unsigned msgs;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    hash_in.valid = 1'b0;
    hash_in.data_word = '0;
    hash_in.byte_count = '0;
    hash_in.last_word = 1'b0;
    words_sent = 0;
    burst_left = 0;
    msgs = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty message, every tail length, extremes and oddities.
    send_message(0, 4'd0);
    for (int c = 1; c <= 8; c++) send_message(0, c[3:0]);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    send_word(64'h0, 4'd8, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
    send_word(rand64(), 4'd9, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0);
    send_word(64'h0, 4'd0, 1'b0);
    send_message(3, 4'd8);
    send_message(4, 4'd0);
    send_message(7, 4'd7);

    // Pause until every hash has come back.
    drain();

    seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    seeds[1] = 64'h0000_0000_0000_0001;
    seeds[2] = rand64();
    seeds[3] = 64'h0;
    foreach (seeds[s]) begin
      write_seed(seeds[s]);
      if (s == 0) begin
        send_message(0, 4'd0);
        send_message(4, 4'd5);
      end
      while (words_sent < 25 + (s + 1) * 280) begin
        r = $urandom_range(0, 9);
        if (r < 7)
          send_message($urandom_range(0, 11), 4'($urandom_range(0, 8)));
        else if (r == 7)
          send_message($urandom_range(0, 2), 4'($urandom_range(0, 15)));
        else if (r == 8)
          send_message($urandom_range(12, 24), 4'($urandom_range(0, 8)));
        else
          send_word(rand64(), 4'($urandom_range(0, 7)), 1'b0);
        msgs++;
      end
      drain();
    end

    $display("covered %0d words in %0d random messages over 5 seed settings",
             words_sent, msgs);
    $display("%0d hashes checked, %0d mismatches",
             hash_sb.hashes_checked, hash_sb.mismatches);
    if (hash_sb.mismatches == 0 && hash_sb.hash_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

>>> xxhash64_stream_hasher_top.f
+incdir+rtl
rtl/xxh64_pkg.sv
rtl/xxh64_if.sv
rtl/xxhash64_stream_hasher_top.sv
tb/xxh64_scoreboard.sv
tb/testbench.sv
